>>> sv/hash_tag_crc32_node_select_unit_macros.svh
// assertion macros for the key-to-node selector
`ifndef HASH_TAG_CRC32_NODE_SELECT_UNIT_MACROS_SVH
`define HASH_TAG_CRC32_NODE_SELECT_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcns assertion failed");

// next-cycle implication, checked outside reset
`define HCNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcns assertion failed");

`endif

>>> sv/hcns_pkg.sv
package hcns_pkg;

  localparam int MaxNodes = 1024;
  localparam int CountW   = 11;
  localparam int IndexW   = 10;
  localparam int HashW    = 32;
  localparam int ProdW    = HashW + CountW;

  localparam logic [HashW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [HashW-1:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0] OpenBrace  = 8'h7B;
  localparam logic [7:0] CloseBrace = 8'h7D;
  localparam logic [7:0] NulByte    = 8'h00;

  typedef logic [CountW-1:0] count_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [HashW-1:0]  hash_t;
  typedef logic [ProdW-1:0]  prod_t;

  // reflected crc-32, one byte, lsb first
  function automatic hash_t crc32_byte(hash_t crc, logic [7:0] b);
    hash_t c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic count_t clamp_count(count_t v);
    count_t r;
    r = v;
    if (v == '0) begin
      r = count_t'(1);
    end else if (v > count_t'(MaxNodes)) begin
      r = count_t'(MaxNodes);
    end
    return r;
  endfunction

endpackage

>>> sv/hash_tag_crc32_node_select_unit.sv
// Key-to-node selector: takes a key one byte per transaction (last_byte marks the final byte)
// and returns one transaction per key carrying the CRC-32 of the brace hash tag, or of the
// whole key when no closed tag was found, plus the node index hash*node_count/0xFFFFFFFF
// clamped to node_count-1. One byte is accepted every cycle while in_stall is low; the
// running CRC and brace tracking update in the cycle the byte is taken, and the result
// passes through the hash register, multiply register and output register. The user must
// write node_count over its own port (ready always high) only while the block is idle; the
// block does not enforce it. 0 acts as 1, values above 1024 act as 1024.
module hash_tag_crc32_node_select_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        key_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output hcns_pkg::index_t  node_index,
  output hcns_pkg::hash_t   key_hash,
  output logic              tag_used,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  hcns_pkg::count_t  node_count
);
  import hcns_pkg::*;

  typedef enum logic [1:0] {PH_BEFORE, PH_INSIDE, PH_CLOSED} phase_t;

  phase_t phase, phase_next;
  logic   stopped, stopped_next;
  hash_t  crc_whole, crc_whole_next;
  hash_t  crc_tag, crc_tag_next;
  count_t count_eff;

  logic   s1_valid, s2_valid;
  hash_t  s1_hash, s2_hash;
  logic   s1_used, s2_used;
  prod_t  s2_prod;

  logic   out_ready, s2_ready, s1_ready, accept;
  logic   used_next;
  hash_t  hash_final;

  logic [CountW-1:0] prod_hi;
  logic [HashW:0]    low_sum;
  logic              round_up;
  count_t            quot, pos;

  assign cfg_ready = 1'b1;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && s1_ready;

  always_comb begin
    crc_whole_next = crc32_byte(crc_whole, key_byte);
    phase_next     = phase;
    stopped_next   = stopped;
    crc_tag_next   = crc_tag;
    if (!stopped && phase != PH_CLOSED) begin
      if (key_byte == NulByte) begin
        stopped_next = 1'b1;
      end else if (phase == PH_BEFORE) begin
        if (key_byte == OpenBrace) begin
          phase_next = PH_INSIDE;
        end
      end else if (key_byte == CloseBrace) begin
        phase_next = PH_CLOSED;
      end else begin
        crc_tag_next = crc32_byte(crc_tag, key_byte);
      end
    end
    used_next  = (phase_next == PH_CLOSED);
    hash_final = used_next ? ~crc_tag_next : ~crc_whole_next;
  end

  // divide by 2^32-1: hi + carry of (hi + lo) past 2^32-1
  always_comb begin
    prod_hi  = s2_prod[ProdW-1:HashW];
    low_sum  = {1'b0, s2_prod[HashW-1:0]} + {{(HashW+1-CountW){1'b0}}, prod_hi};
    round_up = (low_sum >= {1'b0, CrcInit});
    quot     = prod_hi + count_t'(round_up);
    pos      = (quot >= count_eff) ? (count_eff - count_t'(1)) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BEFORE;
      stopped   <= 1'b0;
      crc_whole <= CrcInit;
      crc_tag   <= CrcInit;
      count_eff <= count_t'(1);
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        count_eff <= clamp_count(node_count);
      end
      if (accept) begin
        if (last_byte) begin
          phase     <= PH_BEFORE;
          stopped   <= 1'b0;
          crc_whole <= CrcInit;
          crc_tag   <= CrcInit;
        end else begin
          phase     <= phase_next;
          stopped   <= stopped_next;
          crc_whole <= crc_whole_next;
          crc_tag   <= crc_tag_next;
        end
      end
      if (s1_ready) begin
        s1_valid <= accept && last_byte;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      s1_hash <= hash_final;
      s1_used <= used_next;
    end
    if (s2_ready && s1_valid) begin
      s2_prod <= prod_t'(s1_hash) * prod_t'(count_eff);
      s2_hash <= s1_hash;
      s2_used <= s1_used;
    end
    if (out_ready && s2_valid) begin
      node_index <= pos[IndexW-1:0];
      key_hash   <= s2_hash;
      tag_used   <= s2_used;
    end
  end

endmodule

>>> sv/hcns_checker.sv
`include "hash_tag_crc32_node_select_unit_macros.svh"

module hcns_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             last_byte,
  input logic             out_valid,
  input logic             out_stall,
  input hcns_pkg::index_t node_index,
  input hcns_pkg::hash_t  key_hash,
  input logic             tag_used
);
  import hcns_pkg::*;

  logic                  last_fire;
  logic [IndexW+HashW:0] out_word;

  assign last_fire = in_valid && !in_stall && last_byte;
  assign out_word  = {node_index, key_hash, tag_used};

  // held result stays put
  `HCNS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // empty output register means the input side is free
  `HCNS_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

  // a zero hash always lands on the first node
  `HCNS_ASSERT_NOW(a_zero_hash_node, out_valid && key_hash == '0, node_index == '0)

  // a new result comes from an accepted final byte via the hash, multiply and output registers
  `HCNS_ASSERT_NOW(a_result_has_source, $rose(out_valid), $past(last_fire, 3))

endmodule

bind hash_tag_crc32_node_select_unit hcns_checker u_hcns_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_byte  (last_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .node_index (node_index),
  .key_hash   (key_hash),
  .tag_used   (tag_used)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import hcns_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;
  localparam int KeyBytes    = 1500;
  localparam int IdlePercent = 16;

  typedef enum logic [1:0] {SEEK_OPEN, IN_TAG, TAG_CLOSED} tag_phase_e;

  typedef struct packed {
    index_t node;
    hash_t  hash;
    logic   used;
  } node_pick_t;

  class key_node_predictor;
    count_t       nodes;
    tag_phase_e   phase;
    bit           stopped;
    hash_t        crc_key;
    hash_t        crc_tag;
    node_pick_t   due_picks[$];
    int unsigned  mismatches;

    function new();
      nodes = count_t'(1);
      mismatches = 0;
      clear_key();
    endfunction

    static function hash_t crc_step(hash_t c, logic [7:0] b);
      hash_t r;
      r = c ^ hash_t'(b);
      for (int i = 0; i < 8; i++) begin
        if (r[0]) begin
          r = (r >> 1) ^ CrcPoly;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    function void clear_key();
      phase = SEEK_OPEN;
      stopped = 1'b0;
      crc_key = CrcInit;
      crc_tag = CrcInit;
    endfunction

    function void set_nodes(count_t v);
      nodes = v;
    endfunction

    // one accepted key byte
    function void take_byte(logic [7:0] b, logic fin);
      logic [63:0] n;
      logic [63:0] q;
      node_pick_t  p;
      crc_key = crc_step(crc_key, b);
      if (!stopped && phase != TAG_CLOSED) begin
        if (b == NulByte) begin
          stopped = 1'b1;
        end else if (phase == SEEK_OPEN) begin
          if (b == OpenBrace) begin
            phase = IN_TAG;
          end
        end else if (b == CloseBrace) begin
          phase = TAG_CLOSED;
        end else begin
          crc_tag = crc_step(crc_tag, b);
        end
      end
      if (fin) begin
        p.used = (phase == TAG_CLOSED);
        p.hash = (p.used ? crc_tag : crc_key) ^ CrcInit;
        n = 64'(nodes);
        if (n == 0) begin
          n = 64'd1;
        end else if (n > MaxNodes) begin
          n = 64'(MaxNodes);
        end
        q = (64'(p.hash) * n) / 64'h0000_0000_FFFF_FFFF;
        if (q >= n) begin
          q = n - 64'd1;
        end
        p.node = index_t'(q);
        due_picks.push_back(p);
        clear_key();
      end
    endfunction

    // one accepted result transaction
    function void match_result(index_t node, hash_t hash, logic used);
      node_pick_t e;
      if (due_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: node %0d hash %h tag %0b", node, hash, used);
        end
      end else begin
        e = due_picks.pop_front();
        if (e.node !== node || e.hash !== hash || e.used !== used) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected node %0d hash %h tag %0b, got node %0d hash %h tag %0b",
                     e.node, e.hash, e.used, node, hash, used);
          end
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] key_byte = '0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  index_t     node_index;
  hash_t      key_hash;
  logic       tag_used;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  count_t     node_count = '0;

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  key_node_predictor picks = new();

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  hash_tag_crc32_node_select_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_byte   (key_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .node_index (node_index),
    .key_hash   (key_hash),
    .tag_used   (tag_used),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .node_count (node_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rx_idle && ($urandom_range(99) < IdlePercent);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_fire) begin
        picks.set_nodes(node_count);
      end
      if (in_fire) begin
        picks.take_byte(key_byte, last_byte);
      end
      if (out_fire) begin
        picks.match_result(node_index, key_hash, tag_used);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (tx_idle && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    key_byte  <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_key(input logic [7:0] k[$]);
    for (int i = 0; i < k.size(); i++) begin
      send_byte(k[i], i == k.size() - 1);
    end
  endtask

  // zero byte then the running crc bytes drive the raw crc to zero
  task automatic send_max_hash_key();
    logic [7:0] k[$];
    logic [7:0] b;
    hash_t      c;
    b = 8'($urandom_range(255));
    c = key_node_predictor::crc_step(CrcInit, NulByte);
    c = key_node_predictor::crc_step(c, b);
    k = '{NulByte, b, c[7:0], c[15:8], c[23:16], c[31:24]};
    send_key(k);
  endtask

  function automatic logic [7:0] any_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return OpenBrace;
    end else if (r < 16) begin
      return CloseBrace;
    end else if (r < 21) begin
      return NulByte;
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == OpenBrace || b == CloseBrace || b == NulByte);
    return b;
  endfunction

  task automatic send_random_key();
    logic [7:0] k[$];
    if ($urandom_range(99) < 70) begin
      repeat ($urandom_range(6)) k.push_back(plain_byte());
      k.push_back(OpenBrace);
      repeat ($urandom_range(8)) k.push_back(plain_byte());
      k.push_back(CloseBrace);
      repeat ($urandom_range(6)) k.push_back(any_byte());
    end else begin
      repeat ($urandom_range(1, 16)) k.push_back(any_byte());
    end
    send_key(k);
  endtask

  // sender holds off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (picks.due_picks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_nodes(input count_t v);
    drain();
    cfg_valid  <= 1'b1;
    node_count <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    count_t     phase_counts[$];
    int unsigned phase_bytes;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed keys
    write_nodes(count_t'(7));
    send_key('{NulByte});
    send_key('{8'hFF});
    send_key('{OpenBrace, CloseBrace});
    send_key('{OpenBrace, 8'h61, CloseBrace});
    send_key('{OpenBrace, 8'h61, NulByte, CloseBrace});
    send_key('{OpenBrace, OpenBrace, CloseBrace, CloseBrace});
    send_max_hash_key();

    // random keys over several node counts
    phase_counts = '{count_t'(0), count_t'(1), count_t'(MaxNodes), count_t'(2047),
                     count_t'(5), count_t'($urandom_range(2047)),
                     count_t'($urandom_range(2, 1023)), count_t'(1000)};
    phase_bytes = KeyBytes / phase_counts.size();
    foreach (phase_counts[p]) begin
      write_nodes(phase_counts[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      send_max_hash_key();
      while (bytes_sent < phase_bytes * (p + 1)) begin
        send_random_key();
        if (p == 4 && bytes_sent >= phase_bytes * p + phase_bytes / 2 &&
            bytes_sent < phase_bytes * p + phase_bytes / 2 + 4) begin
          drain();
        end
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (picks.mismatches == 0 && picks.due_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/hcns_pkg.sv
sv/hash_tag_crc32_node_select_unit.sv
sv/hcns_checker.sv
tb/tb.sv
